// File: design/mailbox_tx_queue_controller_unit_defines.svh
// assertion macros for the mailbox transmit queue controller
`ifndef MAILBOX_TX_QUEUE_CONTROLLER_UNIT_DEFINES_SVH
`define MAILBOX_TX_QUEUE_CONTROLLER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define MTQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtq check failed");
// antecedent implies consequent in the next cycle
`define MTQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtq check failed");
`else
`define MTQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MTQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/mtq_pkg.sv
`default_nettype none

package mtq_pkg;

    // default sizes
    localparam int DEF_NUM_CHANNELS = 16;
    localparam int DEF_QUEUE_DEPTH  = 16;

    // depth of the command queue between front and back
    localparam int CMDQ_DEPTH = 2;

    // register port
    localparam int              REG_ADDR_W       = 2;
    localparam logic [REG_ADDR_W-1:0] ADDR_DONE_METHOD = 2'd0;

    // request codes
    localparam logic [2:0] REQ_SEND      = 3'd0;
    localparam logic [2:0] REQ_CTRL_DONE = 3'd1;
    localparam logic [2:0] REQ_ACK_DONE  = 3'd2;
    localparam logic [2:0] REQ_POLL      = 3'd3;
    localparam logic [2:0] REQ_CLAIM     = 3'd4;
    localparam logic [2:0] REQ_RELEASE   = 3'd5;

    // done methods
    localparam logic [1:0] METHOD_IRQ  = 2'd0;
    localparam logic [1:0] METHOD_POLL = 2'd1;
    localparam logic [1:0] METHOD_ACK  = 2'd2;

    // classified operation handed to the back part
    typedef enum logic [2:0] {
        OP_SEND,
        OP_UNOWNED,
        OP_DONE,
        OP_ACK,
        OP_POLL,
        OP_CLAIM,
        OP_RELEASE,
        OP_REJECT
    } op_t;

    // result kinds
    typedef enum logic [2:0] {
        KIND_QUEUED      = 3'd0,
        KIND_FULL        = 3'd1,
        KIND_UNOWNED     = 3'd2,
        KIND_DISPATCHED  = 3'd3,
        KIND_COMPLETED   = 3'd4,
        KIND_NOT_ALLOWED = 3'd5
    } kind_t;

    // back part sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOOK,
        BK_DISP,
        BK_CMPL
    } bk_state_t;

    // one queued command word
    typedef struct packed {
        op_t         op;
        logic [3:0]  channel;
        logic [31:0] message;
        logic        status;
        logic        accepts;
        logic        rdone;
        logic        ack_flag;
    } cmd_t;

endpackage

`default_nettype wire

// File: design/mtq_front.sv
`default_nettype none

module mtq_front import mtq_pkg::*; #(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [3:0]  channel,
    input  logic [31:0] message,
    input  logic        done_status,
    input  logic        link_accepts,
    input  logic        remote_done,
    input  logic        client_acks,
    input  logic [1:0]  done_method,
    input  logic        cq_full,
    output logic        cq_push,
    output cmd_t        cq_cmd
);

    logic ch_ok;
    logic keep;

    assign ch_ok = {28'b0, channel} < 32'(NUM_CHANNELS);

    // classify the request against the done method
    always_comb
    begin
        keep             = ch_ok;
        cq_cmd.op        = OP_REJECT;
        cq_cmd.channel   = channel;
        cq_cmd.message   = message;
        cq_cmd.status    = done_status;
        cq_cmd.accepts   = link_accepts;
        cq_cmd.rdone     = remote_done;
        cq_cmd.ack_flag  = (done_method == METHOD_POLL) && client_acks;
        unique case (req_type)
            REQ_SEND:
            begin
                keep      = 1'b1;
                cq_cmd.op = ch_ok ? OP_SEND : OP_UNOWNED;
            end
            REQ_CTRL_DONE:
            begin
                cq_cmd.op = (done_method == METHOD_IRQ) ? OP_DONE : OP_REJECT;
            end
            REQ_ACK_DONE:
            begin
                if (done_method == METHOD_ACK)
                begin
                    cq_cmd.op = OP_DONE;
                end
                else if (done_method == METHOD_POLL)
                begin
                    cq_cmd.op = OP_ACK;
                end
                else
                begin
                    cq_cmd.op = OP_REJECT;
                end
            end
            REQ_POLL:
            begin
                cq_cmd.op     = (done_method == METHOD_POLL) ? OP_POLL : OP_REJECT;
                cq_cmd.status = 1'b0;
            end
            REQ_CLAIM:
            begin
                cq_cmd.op = OP_CLAIM;
            end
            REQ_RELEASE:
            begin
                cq_cmd.op = OP_RELEASE;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // accept while the command queue has room
    assign busy    = cq_full;
    assign cq_push = start && !busy && keep;

endmodule

`default_nettype wire

// File: design/mtq_cmd_fifo.sv
`default_nettype none

module mtq_cmd_fifo import mtq_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd,
    input  logic pop
);

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t             entry_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full       = (cnt_reg == CNT_W'(CMDQ_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: design/mtq_back.sv
`default_nettype none

module mtq_back import mtq_pkg::*; #(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cq_valid,
    input  cmd_t        cq_cmd,
    output logic        cq_pop,
    output logic        out_valid,
    output logic [2:0]  kind,
    output logic [3:0]  out_channel,
    output logic [31:0] out_message,
    output logic [3:0]  slot,
    output logic        status,
    output logic        last
);

    localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int ST_DEPTH = NUM_CHANNELS * QUEUE_DEPTH;
    localparam int ST_AW    = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;

    // per-channel context word
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [SLOT_W-1:0] ws;
        logic [31:0]       ifmsg;
    } ctx_t;

    bk_state_t state_reg;
    bk_state_t state_next;

    cmd_t              item_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SLOT_W-1:0] ws_reg;
    logic [31:0]       ifmsg_reg;
    logic              cmpl_reg;
    logic              bypass_reg;

    logic [NUM_CHANNELS-1:0] owned_reg;
    logic [NUM_CHANNELS-1:0] owned_next;
    logic [NUM_CHANNELS-1:0] ack_reg;
    logic [NUM_CHANNELS-1:0] ack_next;
    logic [NUM_CHANNELS-1:0] ifv_reg;
    logic [NUM_CHANNELS-1:0] ifv_next;

    ctx_t              ctx_mem [NUM_CHANNELS];
    ctx_t              ctx_rd_reg;
    logic [CH_W-1:0]   ctx_raddr;
    logic              ctx_we;
    ctx_t              ctx_wdata;

    logic [31:0]       store_mem [ST_DEPTH];
    logic [31:0]       st_rd_reg;
    logic [ST_AW-1:0]  st_waddr;
    logic [ST_AW-1:0]  st_raddr;
    logic              st_we;

    logic [CH_W-1:0]   ch_idx;
    logic              own;
    logic              ifv;
    logic              ackf;
    logic              full_q;
    logic [SLOT_W-1:0] ws_inc;
    logic [CNT_W:0]    diff;
    logic [SLOT_W-1:0] rd_slot;
    logic [31:0]       disp_msg;

    logic              tick;
    logic              had;
    logic              go_disp;
    logic              bypass;
    logic [CNT_W-1:0]  cnt_upd;
    logic [SLOT_W-1:0] ws_upd;

    logic              res_valid;
    kind_t             res_kind;
    logic [31:0]       res_msg;
    logic [3:0]        res_slot;
    logic              res_status;
    logic              res_last;

    logic              out_valid_reg;
    kind_t             kind_reg;
    logic [3:0]        channel_reg;
    logic [31:0]       message_reg;
    logic [3:0]        slot_reg;
    logic              status_reg;
    logic              last_reg;

    // lookup of the addressed channel
    assign ch_idx    = CH_W'(item_reg.channel);
    assign ctx_raddr = CH_W'(cq_cmd.channel);
    assign own       = owned_reg[ch_idx];
    assign ifv       = ifv_reg[ch_idx];
    assign ackf      = ack_reg[ch_idx];
    assign full_q    = ctx_rd_reg.cnt >= CNT_W'(QUEUE_DEPTH);
    assign ws_inc    = (ctx_rd_reg.ws == SLOT_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : ctx_rd_reg.ws + 1'b1;

    // oldest queued slot: write slot minus count, modulo the ring depth
    always_comb
    begin
        diff = (CNT_W + 1)'(ctx_rd_reg.ws) - (CNT_W + 1)'(ctx_rd_reg.cnt);
        if (ctx_rd_reg.ws < SLOT_W'(ctx_rd_reg.cnt) || ctx_rd_reg.cnt > CNT_W'(ctx_rd_reg.ws))
        begin
            diff = diff + (CNT_W + 1)'(QUEUE_DEPTH);
        end
        rd_slot = SLOT_W'(diff);
    end

    assign st_waddr = ST_AW'(ch_idx) * ST_AW'(QUEUE_DEPTH) + ST_AW'(ctx_rd_reg.ws);
    assign st_raddr = ST_AW'(ch_idx) * ST_AW'(QUEUE_DEPTH) + ST_AW'(rd_slot);
    assign disp_msg = bypass_reg ? item_reg.message : st_rd_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cq_valid)
                begin
                    state_next = BK_LOOK;
                end
            end
            BK_LOOK:
            begin
                state_next = go_disp ? BK_DISP : BK_IDLE;
            end
            BK_DISP:
            begin
                state_next = cmpl_reg ? BK_CMPL : BK_IDLE;
            end
            BK_CMPL:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs: results, state writes and flag updates
    always_comb
    begin
        cq_pop     = 1'b0;
        res_valid  = 1'b0;
        res_kind   = KIND_QUEUED;
        res_msg    = item_reg.message;
        res_slot   = 4'd0;
        res_status = 1'b0;
        res_last   = 1'b1;
        st_we      = 1'b0;
        ctx_we     = 1'b0;
        ctx_wdata  = ctx_rd_reg;
        owned_next = owned_reg;
        ack_next   = ack_reg;
        ifv_next   = ifv_reg;
        tick       = 1'b0;
        had        = 1'b0;
        go_disp    = 1'b0;
        bypass     = 1'b0;
        cnt_upd    = ctx_rd_reg.cnt;
        ws_upd     = ctx_rd_reg.ws;
        unique case (state_reg)
            BK_IDLE:
            begin
                cq_pop = cq_valid;
            end
            BK_LOOK:
            begin
                case (item_reg.op)
                    OP_UNOWNED:
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_UNOWNED;
                    end
                    OP_SEND:
                    begin
                        res_valid = 1'b1;
                        if (!own)
                        begin
                            res_kind = KIND_UNOWNED;
                        end
                        else if (full_q)
                        begin
                            res_kind = KIND_FULL;
                        end
                        else
                        begin
                            st_we           = 1'b1;
                            ctx_we          = 1'b1;
                            cnt_upd         = ctx_rd_reg.cnt + 1'b1;
                            ws_upd          = ws_inc;
                            ctx_wdata.cnt   = cnt_upd;
                            ctx_wdata.ws    = ws_inc;
                            res_kind        = KIND_QUEUED;
                            res_slot        = 4'(ctx_rd_reg.ws);
                            go_disp         = !ifv && item_reg.accepts;
                            res_last        = !go_disp;
                            bypass          = (ctx_rd_reg.cnt == '0);
                        end
                    end
                    OP_REJECT:
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_NOT_ALLOWED;
                        res_msg   = 32'd0;
                    end
                    OP_ACK:
                    begin
                        if (!ackf)
                        begin
                            res_valid = 1'b1;
                            res_kind  = KIND_NOT_ALLOWED;
                            res_msg   = 32'd0;
                        end
                        else
                        begin
                            tick = own;
                        end
                    end
                    OP_DONE:
                    begin
                        tick = own;
                    end
                    OP_POLL:
                    begin
                        tick = own && ifv && item_reg.rdone;
                    end
                    OP_CLAIM:
                    begin
                        if (!own)
                        begin
                            owned_next[ch_idx] = 1'b1;
                            ifv_next[ch_idx]   = 1'b0;
                            ack_next[ch_idx]   = item_reg.ack_flag;
                            ctx_we             = 1'b1;
                            ctx_wdata.cnt      = '0;
                            ctx_wdata.ws       = '0;
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (own)
                        begin
                            owned_next[ch_idx] = 1'b0;
                            ifv_next[ch_idx]   = 1'b0;
                            ack_next[ch_idx]   = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                // done event: release in-flight word, maybe dispatch the next
                if (tick)
                begin
                    had              = ifv;
                    ifv_next[ch_idx] = 1'b0;
                    go_disp          = (ctx_rd_reg.cnt != '0) && item_reg.accepts;
                    if (!go_disp && had)
                    begin
                        res_valid  = 1'b1;
                        res_kind   = KIND_COMPLETED;
                        res_msg    = ctx_rd_reg.ifmsg;
                        res_status = item_reg.status;
                    end
                end
            end
            BK_DISP:
            begin
                res_valid        = 1'b1;
                res_kind         = KIND_DISPATCHED;
                res_msg          = disp_msg;
                res_last         = !cmpl_reg;
                ifv_next[ch_idx] = 1'b1;
                ctx_we           = 1'b1;
                ctx_wdata.cnt    = cnt_reg - 1'b1;
                ctx_wdata.ws     = ws_reg;
                ctx_wdata.ifmsg  = disp_msg;
            end
            BK_CMPL:
            begin
                res_valid  = 1'b1;
                res_kind   = KIND_COMPLETED;
                res_msg    = ifmsg_reg;
                res_status = item_reg.status;
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            owned_reg     <= '0;
            ack_reg       <= '0;
            ifv_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            owned_reg     <= owned_next;
            ack_reg       <= ack_next;
            ifv_reg       <= ifv_next;
            out_valid_reg <= res_valid;
        end
    end

    // working registers of the current word
    always_ff @(posedge clk)
    begin
        if (cq_pop)
        begin
            item_reg <= cq_cmd;
        end
        if (state_reg == BK_LOOK)
        begin
            cnt_reg    <= cnt_upd;
            ws_reg     <= ws_upd;
            ifmsg_reg  <= ctx_rd_reg.ifmsg;
            cmpl_reg   <= had;
            bypass_reg <= bypass;
        end
        if (res_valid)
        begin
            kind_reg    <= res_kind;
            channel_reg <= item_reg.channel;
            message_reg <= res_msg;
            slot_reg    <= res_slot;
            status_reg  <= res_status;
            last_reg    <= res_last;
        end
    end

    // channel context memory
    always_ff @(posedge clk)
    begin
        if (ctx_we)
        begin
            ctx_mem[ch_idx] <= ctx_wdata;
        end
        ctx_rd_reg <= ctx_mem[ctx_raddr];
    end

    // message ring memory
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_waddr] <= item_reg.message;
        end
        st_rd_reg <= store_mem[st_raddr];
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign out_channel = channel_reg;
    assign out_message = message_reg;
    assign slot        = slot_reg;
    assign status      = status_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// File: design/mailbox_tx_queue_controller_unit.sv
// channel    direction  handshake                         payload
// command    in         start, busy (taken: start & !busy) req_type channel message done_status
//                                                          link_accepts remote_done client_acks
// result     out        out_valid, one cycle, no stall    kind out_channel out_message slot
//                                                          status last
// register   in/out     apb write: psel penable pwrite    paddr pwdata prdata
//
// a command word is classified on acceptance and waits in a two-entry queue;
// the back part handles each word in steps (queue pop, context lookup), plus a
// dispatch step and a completion step that follows a dispatch; it takes no new
// word before it is through with the last one. its pace is set by the per-channel
// context memory read and the ring read; results appear in the cycle after they
// are formed, a word's results back to back. reset clears ownership, in-flight
// flags and the done method; busy is high only while the command queue is full.
`default_nettype none
`include "mailbox_tx_queue_controller_unit_defines.svh"

module mailbox_tx_queue_controller_unit import mtq_pkg::*; #(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            req_type,
    input  logic [3:0]            channel,
    input  logic [31:0]           message,
    input  logic                  done_status,
    input  logic                  link_accepts,
    input  logic                  remote_done,
    input  logic                  client_acks,
    output logic                  out_valid,
    output logic [2:0]            kind,
    output logic [3:0]            out_channel,
    output logic [31:0]           out_message,
    output logic [3:0]            slot,
    output logic                  status,
    output logic                  last,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [1:0] done_method_reg;
    logic       reg_wr;
    logic       cq_push;
    logic       cq_full;
    logic       cq_valid;
    logic       cq_pop;
    cmd_t       push_cmd;
    cmd_t       head_cmd;
    logic       reject_word;

    // register port
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready && (paddr == ADDR_DONE_METHOD);
    assign prdata = (paddr == ADDR_DONE_METHOD) ? 32'(done_method_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_method_reg <= METHOD_IRQ;
        end
        else if (reg_wr)
        begin
            done_method_reg <= pwdata[1:0];
        end
    end

    // front: accept and classify
    mtq_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .channel      (channel),
        .message      (message),
        .done_status  (done_status),
        .link_accepts (link_accepts),
        .remote_done  (remote_done),
        .client_acks  (client_acks),
        .done_method  (done_method_reg),
        .cq_full      (cq_full),
        .cq_push      (cq_push),
        .cq_cmd       (push_cmd)
    );

    // command queue
    mtq_cmd_fifo u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cq_push),
        .push_cmd   (push_cmd),
        .full       (cq_full),
        .head_valid (cq_valid),
        .head_cmd   (head_cmd),
        .pop        (cq_pop)
    );

    // back: per-channel state and message ring
    mtq_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cq_valid    (cq_valid),
        .cq_cmd      (head_cmd),
        .cq_pop      (cq_pop),
        .out_valid   (out_valid),
        .kind        (kind),
        .out_channel (out_channel),
        .out_message (out_message),
        .slot        (slot),
        .status      (status),
        .last        (last)
    );

    // rejection kinds always stand alone
    assign reject_word = out_valid &&
                         (kind == KIND_FULL || kind == KIND_UNOWNED || kind == KIND_NOT_ALLOWED);

    // checks
    `MTQ_ASSERT_IMP(a_push_has_room, clk, rst_n, cq_push, !cq_full)
    `MTQ_ASSERT_NXT(a_pair_back_to_back, clk, rst_n, out_valid && !last, out_valid)
    `MTQ_ASSERT_IMP(a_reject_single, clk, rst_n, reject_word, last)

endmodule

`default_nettype wire
